// ===== design/pml_pkg.sv =====
// pml_pkg: shared types and register codes for the progress measure lift unit
// no dependencies
package pml_pkg;

  typedef enum logic [2:0] {
    REG_PLAYER       = 3'd0,
    REG_ACTIVE       = 3'd1,
    REG_MEASURE_MAX  = 3'd2,
    REG_OPPONENT_MAX = 3'd3,
    REG_GOAL         = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic       player;
    logic [3:0] active_components;
    logic [7:0] measure_max;
    logic [7:0] opponent_max;
    logic [7:0] goal;
  } cfg_t;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 8;

endpackage

// ===== design/pml_less.sv =====
// pml_less: strict order compare of two packed measures over k components
// depends on nothing but its parameters
module pml_less #(
  parameter int MC = 8,
  parameter int CB = 8
) (
  input  logic [MC*CB-1:0] a,
  input  logic [MC*CB-1:0] b,
  input  logic [3:0]       k,
  input  logic             pl,
  output logic             lt
);

  localparam logic [CB-1:0] BLANK_C = {CB{1'b1}};

  always_comb begin
    logic [CB-1:0] ca;
    logic [CB-1:0] cb;
    logic ap;
    logic bp;
    lt = 1'b0;
    // lowest differing component decides
    for (int i = MC - 1; i >= 0; i--) begin
      ca = a[(MC-1-i)*CB +: CB];
      cb = b[(MC-1-i)*CB +: CB];
      ap = (ca[0] == pl);
      bp = (cb[0] == pl);
      if ((4'(i) < k) && (ca != cb)) begin
        if (ca == BLANK_C) begin
          lt = 1'b1;
        end else if (cb == BLANK_C) begin
          lt = 1'b0;
        end else if (ap) begin
          lt = bp ? (ca < cb) : 1'b0;
        end else begin
          lt = bp ? 1'b1 : (ca > cb);
        end
      end
    end
  end

endmodule

// ===== design/pml_front.sv =====
// pml_front: two stage front end, forms the antagonistic update of each successor
// depends on pml_pkg and pml_less
module pml_front import pml_pkg::*; #(
  parameter int MC = 8,
  parameter int CB = 8,
  parameter int IB = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic [3:0]       k,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [MC*CB-1:0] current_measure,
  input  logic [MC*CB-1:0] successor_measure,
  input  logic [7:0]       priority_req,
  input  logic             owner_is_player,
  input  logic [IB-1:0]    successor_id,
  input  logic             first_successor,
  input  logic             last_successor,
  output logic             f_valid,
  input  logic             f_ready,
  output logic [MC*CB-1:0] f_cand,
  output logic [MC*CB-1:0] f_cur,
  output logic             f_owner,
  output logic [IB-1:0]    f_id,
  output logic             f_first,
  output logic             f_last
);

  localparam int W = MC * CB;
  localparam int BLANK = (1 << CB) - 1;
  localparam int IW = $clog2(MC);
  localparam logic [CB-1:0] BLANK_C = {CB{1'b1}};

  function automatic logic [CB-1:0] comp(input logic [W-1:0] x, input int i);
    return x[(MC-1-i)*CB +: CB];
  endfunction

  function automatic logic is_pl(input logic [CB-1:0] c, input logic pl);
    return (c != BLANK_C) && (c[0] == pl);
  endfunction

  function automatic logic [CB-1:0] clampv(input logic [7:0] v);
    if (9'(v) >= 9'(BLANK)) return CB'(BLANK - 1);
    return v[CB-1:0];
  endfunction

  function automatic logic [W:0] upd(input logic [W-1:0] s, input logic [CB-1:0] d,
                                     input logic [3:0] kk, input logic pl);
    logic [W-1:0]  r;
    logic [IW-1:0] jw;
    logic [IW-1:0] jl;
    logic [IW-1:0] j;
    logic          jw_ok;
    logic          jl_ok;
    logic [CB-1:0] c;
    r = s;
    jw = '0;
    jl = '0;
    jw_ok = 1'b0;
    jl_ok = 1'b0;
    for (int i = 0; i < MC; i++) begin
      c = comp(s, i);
      if ((4'(i) < kk) && !is_pl(c, pl)) begin
        jw = IW'(i);
        jw_ok = 1'b1;
      end
    end
    for (int i = MC - 1; i >= 0; i--) begin
      c = comp(s, i);
      if ((4'(i) < kk) && (c != BLANK_C) && (c < d)) begin
        jl = IW'(i);
        jl_ok = 1'b1;
      end
    end
    if (jl_ok && (!jw_ok || (jl < jw))) j = jl;
    else j = jw;
    if (is_pl(comp(s, 0), pl) || !(jw_ok || jl_ok)) return {1'b0, s};
    for (int i = 0; i < MC; i++) begin
      if (IW'(i) == j) r[(MC-1-i)*CB +: CB] = d;
      else if (IW'(i) > j) r[(MC-1-i)*CB +: CB] = BLANK_C;
    end
    return {1'b1, r};
  endfunction

  function automatic logic [W:0] bmp(input logic [W-1:0] s, input logic [3:0] kk,
                                     input logic [CB-1:0] mx, input logic [CB-1:0] mo,
                                     input logic pl);
    logic [W-1:0]  r;
    logic          hit;
    logic          h;
    logic [IW-1:0] pos;
    logic [CB-1:0] nvs;
    logic [CB-1:0] nv;
    logic [CB-1:0] c;
    logic [CB-1:0] p;
    logic [CB-1:0] plv;
    r = s;
    hit = 1'b0;
    pos = '0;
    nvs = '0;
    plv = {{(CB-1){1'b0}}, pl};
    for (int i = 0; i < MC; i++) begin
      c = comp(s, i);
      p = comp(s, (i > 0) ? i - 1 : 0);
      h = 1'b0;
      nv = '0;
      if (c == BLANK_C) begin
        nv = mo;
        h = 1'b1;
      end else if (c[0] != pl) begin
        if (c > {{(CB-1){1'b0}}, ~pl}) begin
          nv = c - CB'(2);
          h = 1'b1;
        end else if ((i > 0) && (p != BLANK_C) && (p >= plv)) begin
          nv = plv;
          h = 1'b1;
        end
      end else if ((({1'b0, c} + (CB+1)'(2)) <= {1'b0, mx}) && (i > 0) && (p != BLANK_C)
                   && ({1'b0, p} >= ({1'b0, c} + (CB+1)'(2)))) begin
        nv = c + CB'(2);
        h = 1'b1;
      end
      if (h && ((4'(i) + 4'd2) <= kk)) begin
        hit = 1'b1;
        pos = IW'(i);
        nvs = nv;
      end
    end
    for (int i = 0; i < MC; i++) begin
      if (IW'(i) == pos) r[(MC-1-i)*CB +: CB] = nvs;
      else if (IW'(i) > pos) r[(MC-1-i)*CB +: CB] = BLANK_C;
    end
    return {hit, r};
  endfunction

  logic [CB-1:0] mx;
  logic [CB-1:0] mo;
  logic [CB-1:0] d_in;
  logic [W:0]    u1;
  logic [W:0]    b1;

  logic          s1_valid;
  logic [W-1:0]  s1_cand;
  logic [W-1:0]  s1_alt;
  logic          s1_try;
  logic [CB-1:0] s1_d;
  logic [W-1:0]  s1_cur;
  logic          s1_owner;
  logic [IB-1:0] s1_id;
  logic          s1_first;
  logic          s1_last;

  logic          s1_adv;
  logic          s2_adv;
  logic [W:0]    u2;
  logic          alt_lt;
  logic [W-1:0]  cand_sel;
  logic [W-1:0]  cand_next;
  logic [MC-1:0] val;

  assign mx = clampv(cfg.measure_max);
  assign mo = clampv(cfg.opponent_max);
  assign d_in = clampv(priority_req);
  assign u1 = upd(successor_measure, d_in, k, cfg.player);
  assign b1 = bmp(successor_measure, k, mx, mo, cfg.player);

  assign s2_adv = !f_valid || f_ready;
  assign s1_adv = !s1_valid || s2_adv;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_cand  <= u1[W-1:0];
      s1_alt   <= b1[W-1:0];
      s1_try   <= u1[W] && b1[W];
      s1_d     <= d_in;
      s1_cur   <= current_measure;
      s1_owner <= owner_is_player;
      s1_id    <= successor_id;
      s1_first <= first_successor;
      s1_last  <= last_successor;
    end
  end

  assign u2 = upd(s1_alt, s1_d, k, cfg.player);

  pml_less #(.MC(MC), .CB(CB)) u_alt_less (
    .a (u2[W-1:0]),
    .b (s1_cand),
    .k (k),
    .pl(cfg.player),
    .lt(alt_lt)
  );

  always_comb begin
    cand_sel = (s1_try && alt_lt) ? u2[W-1:0] : s1_cand;
    val = '0;
    for (int i = 0; i < MC; i++) begin
      if (4'(i) < k) val = {val[MC-2:0], is_pl(comp(cand_sel, i), cfg.player)};
    end
    cand_next = cand_sel;
    if (8'(val) > cfg.goal) cand_next[W-1 -: CB] = mx;
    for (int i = 0; i < MC; i++) begin
      if (4'(i) >= k) cand_next[(MC-1-i)*CB +: CB] = BLANK_C;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (s2_adv) begin
      f_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      f_cand  <= cand_next;
      f_cur   <= s1_cur;
      f_owner <= s1_owner;
      f_id    <= s1_id;
      f_first <= s1_first;
      f_last  <= s1_last;
    end
  end

endmodule

// ===== design/pml_queue.sv =====
// pml_queue: two entry queue between front and back end
// no dependencies
module pml_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign push = push_valid && push_ready;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count beyond depth");
  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("pop from empty queue");

endmodule

// ===== design/pml_back.sv =====
// pml_back: folds updates into the best measure and emits the vertex result
// depends on pml_pkg and pml_less
module pml_back import pml_pkg::*; #(
  parameter int MC = 8,
  parameter int CB = 8,
  parameter int IB = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic [3:0]       k,
  input  logic             q_valid,
  output logic             q_pop,
  input  logic [MC*CB-1:0] q_cand,
  input  logic [MC*CB-1:0] q_cur,
  input  logic             q_owner,
  input  logic [IB-1:0]    q_id,
  input  logic             q_first,
  input  logic             q_last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [MC*CB-1:0] new_measure,
  output logic             changed,
  output logic [IB-1:0]    chosen_successor
);

  localparam int W = MC * CB;
  localparam logic [CB-1:0] BLANK_C = {CB{1'b1}};

  logic [W-1:0]  best;
  logic [IB-1:0] best_id;
  logic          lt_best_cand;
  logic          lt_cand_best;
  logic          take;
  logic [W-1:0]  nb;
  logic [IB-1:0] nid;
  logic          lt_cur_nb;
  logic [CB-1:0] cur0;
  logic          cur_top;

  pml_less #(.MC(MC), .CB(CB)) u_less_bc (
    .a(best), .b(q_cand), .k(k), .pl(cfg.player), .lt(lt_best_cand)
  );
  pml_less #(.MC(MC), .CB(CB)) u_less_cb (
    .a(q_cand), .b(best), .k(k), .pl(cfg.player), .lt(lt_cand_best)
  );

  assign q_pop = q_valid && (!out_valid || !out_stall);
  assign take = q_first || (q_owner ? lt_best_cand : lt_cand_best);
  assign nb = take ? q_cand : best;
  assign nid = take ? q_id : best_id;

  pml_less #(.MC(MC), .CB(CB)) u_less_res (
    .a(q_cur), .b(nb), .k(k), .pl(cfg.player), .lt(lt_cur_nb)
  );

  assign cur0 = q_cur[W-1 -: CB];
  assign cur_top = (cur0 != BLANK_C) && (cur0[0] == cfg.player);

  always_ff @(posedge clk) begin
    if (q_pop && take) begin
      best    <= q_cand;
      best_id <= q_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_last) begin
      if (cur_top) begin
        new_measure      <= q_cur;
        changed          <= 1'b0;
        chosen_successor <= '0;
      end else begin
        new_measure      <= lt_cur_nb ? nb : q_cur;
        changed          <= lt_cur_nb;
        chosen_successor <= nid;
      end
    end
  end

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_last) |=> out_valid)
    else $error("last successor gave no result");

endmodule

// ===== design/progress_measure_lift_unit.sv =====
// progress_measure_lift_unit: lifts one parity game vertex over its successors.
// One successor word is accepted per clock while in_stall is low; each word runs through a two stage
// front end (update and bump, then bumped update, pick and goal check), a two
// entry queue and a registered fold in the back end. The fold register carries
// the only loop.
// depends on pml_pkg, pml_front, pml_queue, pml_back
module progress_measure_lift_unit import pml_pkg::*; #(
  parameter int MAX_COMPONENTS = 8,
  parameter int COMPONENT_BITS = 8,
  parameter int ID_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]               cfg_index,
  input  logic [CFG_DATA_BITS-1:0]                cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [MAX_COMPONENTS*COMPONENT_BITS-1:0] current_measure,
  input  logic [MAX_COMPONENTS*COMPONENT_BITS-1:0] successor_measure,
  input  logic [7:0]                              priority_req,
  input  logic                                    owner_is_player,
  input  logic [ID_BITS-1:0]                      successor_id,
  input  logic                                    first_successor,
  input  logic                                    last_successor,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [MAX_COMPONENTS*COMPONENT_BITS-1:0] new_measure,
  output logic                                    changed,
  output logic [ID_BITS-1:0]                      chosen_successor
);

  localparam int W = MAX_COMPONENTS * COMPONENT_BITS;
  localparam int QW = 2 * W + ID_BITS + 3;

  cfg_t          cfg;
  logic [3:0]    k;
  logic          f_valid;
  logic          f_ready;
  logic [W-1:0]  f_cand;
  logic [W-1:0]  f_cur;
  logic          f_owner;
  logic [ID_BITS-1:0] f_id;
  logic          f_first;
  logic          f_last;
  logic          q_valid;
  logic          q_pop;
  logic [QW-1:0] q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.player            <= 1'b0;
      cfg.active_components <= 4'd8;
      cfg.measure_max       <= 8'd254;
      cfg.opponent_max      <= 8'd253;
      cfg.goal              <= 8'd255;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PLAYER:       cfg.player <= cfg_data[0];
        REG_ACTIVE:       cfg.active_components <= cfg_data[3:0];
        REG_MEASURE_MAX:  cfg.measure_max <= cfg_data;
        REG_OPPONENT_MAX: cfg.opponent_max <= cfg_data;
        REG_GOAL:         cfg.goal <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg.active_components == 4'd0) k = 4'd1;
    else if (cfg.active_components > 4'(MAX_COMPONENTS)) k = 4'(MAX_COMPONENTS);
    else k = cfg.active_components;
  end

  pml_front #(.MC(MAX_COMPONENTS), .CB(COMPONENT_BITS), .IB(ID_BITS)) u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .k                (k),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .current_measure  (current_measure),
    .successor_measure(successor_measure),
    .priority_req     (priority_req),
    .owner_is_player  (owner_is_player),
    .successor_id     (successor_id),
    .first_successor  (first_successor),
    .last_successor   (last_successor),
    .f_valid          (f_valid),
    .f_ready          (f_ready),
    .f_cand           (f_cand),
    .f_cur            (f_cur),
    .f_owner          (f_owner),
    .f_id             (f_id),
    .f_first          (f_first),
    .f_last           (f_last)
  );

  pml_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data ({f_cand, f_cur, f_owner, f_id, f_first, f_last}),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  pml_back #(.MC(MAX_COMPONENTS), .CB(COMPONENT_BITS), .IB(ID_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .k               (k),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_cand          (q_data[QW-1 -: W]),
    .q_cur           (q_data[QW-W-1 -: W]),
    .q_owner         (q_data[ID_BITS+2]),
    .q_id            (q_data[ID_BITS+1:2]),
    .q_first         (q_data[1]),
    .q_last          (q_data[0]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .new_measure     (new_measure),
    .changed         (changed),
    .chosen_successor(chosen_successor)
  );

endmodule
